// File: sv/flsp_pkg.sv
// ----------------------------------------------------------------------------
// Frame location stream parser package
// Shared result type and stream codes for the parser and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package flsp_pkg;

  // Header nibble codes.
  localparam logic [3:0] END_CODE   = 4'b1111;
  localparam logic [3:0] EMPTY_CODE = 4'b0000;
  localparam int unsigned NIBBLE_BITS = 4;

  // One result word as it is held in the output queue.
  typedef struct packed {
    logic [3:0]  frame_type;
    logic [63:0] frame_location;
    logic        is_frame;
    logic        last_in_run;
    logic        stream_done;
  } result_t;

endpackage

`default_nettype wire

// File: sv/flsp_if.sv
// ----------------------------------------------------------------------------
// Frame location stream parser channels
// Valid/ready channels for the byte stream and for the result words.
// ----------------------------------------------------------------------------
`default_nettype none

// Byte stream channel.
interface flsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

// Result channel.
interface flsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  frame_type;
  logic [63:0] frame_location;
  logic        is_frame;
  logic        last_in_run;
  logic        stream_done;

  modport source (output valid, output frame_type, output frame_location,
                  output is_frame, output last_in_run, output stream_done,
                  input ready);
  modport sink   (input valid, input frame_type, input frame_location,
                  input is_frame, input last_in_run, input stream_done,
                  output ready);
endinterface

`default_nettype wire

// File: sv/frame_location_stream_parser.sv
// ----------------------------------------------------------------------------
// Frame location stream parser
// Parses header bytes and little-endian 64-bit locations into frame results.
// ----------------------------------------------------------------------------
// The parser takes one byte in every cycle while in_chan.ready is high. Each
// accepted word updates the parser state in the same cycle and pushes zero, one
// or two result words into a four-entry output queue, which delivers one word
// per cycle while the receiver is ready. The input is stalled while fewer than
// two queue entries are free, so the sustained input rate is one byte per cycle
// except where pairs of results arrive faster than the output drains them.
// Each result word is held in a queue register before it reaches the output.
`default_nettype none

module frame_location_stream_parser (
  input wire logic      clk,
  input wire logic      rst_n,
  flsp_in_if.sink       in_chan,
  flsp_out_if.source    out_chan
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2,
    PH_ENDED  = 2'd3
  } phase_t;

  localparam int unsigned QDEPTH = 4;

  // Parser state.
  phase_t      phase_r, phase_nxt, eff_phase;
  logic [2:0]  idx_r, idx_nxt;
  logic [3:0]  first_type_r, first_type_nxt;
  logic [3:0]  second_type_r, second_type_nxt;
  logic [63:0] first_loc_r, first_loc_nxt;
  logic [63:0] second_loc_r, second_loc_nxt;
  logic        eaf_r, eaf_nxt;

  // Results of the current word.
  flsp_pkg::result_t res0, res1;
  logic [1:0]  n_res;
  logic        emit;
  logic [3:0]  t1, t2;

  // Output queue.
  flsp_pkg::result_t fifo_r [QDEPTH];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  count_r;
  logic        in_acc, out_acc;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  // Two free entries are needed for the worst case of a word.
  assign in_chan.ready = (count_r <= 3'(QDEPTH - 2));

  assign t1 = in_chan.data_byte[7:4];
  assign t2 = in_chan.data_byte[3:0];

  // Next parser state and results for the word on the input.
  always_comb begin
    phase_nxt       = phase_r;
    idx_nxt         = idx_r;
    first_type_nxt  = first_type_r;
    second_type_nxt = second_type_r;
    first_loc_nxt   = first_loc_r;
    second_loc_nxt  = second_loc_r;
    eaf_nxt         = eaf_r;
    res0            = '0;
    res1            = '0;
    n_res           = 2'd0;
    emit            = 1'b0;
    eff_phase       = in_chan.restart ? PH_HEADER : phase_r;

    unique case (eff_phase)
      PH_HEADER: begin
        idx_nxt = 3'd0;
        if (t1 == flsp_pkg::END_CODE) begin
          // End code first: a single end marker.
          res0.last_in_run = 1'b1;
          res0.stream_done = 1'b1;
          n_res            = 2'd1;
          phase_nxt        = PH_ENDED;
        end else begin
          first_type_nxt  = t1;
          eaf_nxt         = (t2 == flsp_pkg::END_CODE);
          second_type_nxt = eaf_nxt ? flsp_pkg::EMPTY_CODE : t2;
          if (t1 != flsp_pkg::EMPTY_CODE) begin
            phase_nxt = PH_FIRST;
          end else if (!eaf_nxt && t2 != flsp_pkg::EMPTY_CODE) begin
            phase_nxt = PH_SECOND;
          end else begin
            emit = 1'b1;
          end
        end
      end
      PH_FIRST: begin
        first_loc_nxt = {in_chan.data_byte, first_loc_r[63:8]};
        idx_nxt       = 3'(idx_r + 3'd1);
        if (idx_r == 3'd7) begin
          if (!eaf_r && second_type_r != flsp_pkg::EMPTY_CODE) begin
            phase_nxt = PH_SECOND;
          end else begin
            emit = 1'b1;
          end
        end
      end
      PH_SECOND: begin
        second_loc_nxt = {in_chan.data_byte, second_loc_r[63:8]};
        idx_nxt        = 3'(idx_r + 3'd1);
        if (idx_r == 3'd7) begin
          emit = 1'b1;
        end
      end
      PH_ENDED: begin
        // Words after the end are dropped.
      end
      default: begin
      end
    endcase

    // Emit the completed pair, or only the first frame when the stream ends.
    if (emit) begin
      res0.frame_type     = first_type_nxt;
      res0.frame_location = first_loc_nxt;
      res0.is_frame       = 1'b1;
      if (eaf_nxt) begin
        res0.last_in_run = 1'b1;
        res0.stream_done = 1'b1;
        n_res            = 2'd1;
        phase_nxt        = PH_ENDED;
      end else begin
        res1.frame_type     = second_type_nxt;
        res1.frame_location = second_loc_nxt;
        res1.is_frame       = 1'b1;
        res1.last_in_run    = 1'b1;
        n_res               = 2'd2;
        phase_nxt           = PH_HEADER;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      idx_r         <= 3'd0;
      first_type_r  <= flsp_pkg::EMPTY_CODE;
      second_type_r <= flsp_pkg::EMPTY_CODE;
      first_loc_r   <= 64'd0;
      second_loc_r  <= 64'd0;
      eaf_r         <= 1'b0;
    end else if (in_acc) begin
      phase_r       <= phase_nxt;
      idx_r         <= idx_nxt;
      first_type_r  <= first_type_nxt;
      second_type_r <= second_type_nxt;
      first_loc_r   <= first_loc_nxt;
      second_loc_r  <= second_loc_nxt;
      eaf_r         <= eaf_nxt;
    end
  end

  // Queue entries carry payload only.
  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (in_acc && n_res == 2'd2) begin
      fifo_r[2'(wr_ptr_r + 2'd1)] <= res1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= 2'(wr_ptr_r + n_res);
      end
      if (out_acc) begin
        rd_ptr_r <= 2'(rd_ptr_r + 2'd1);
      end
      count_r <= 3'(count_r + (in_acc ? {1'b0, n_res} : 3'd0) - {2'd0, out_acc});
    end
  end

  // Head of the queue drives the result channel.
  assign out_chan.valid          = (count_r != 3'd0);
  assign out_chan.frame_type     = fifo_r[rd_ptr_r].frame_type;
  assign out_chan.frame_location = fifo_r[rd_ptr_r].frame_location;
  assign out_chan.is_frame       = fifo_r[rd_ptr_r].is_frame;
  assign out_chan.last_in_run    = fifo_r[rd_ptr_r].last_in_run;
  assign out_chan.stream_done    = fifo_r[rd_ptr_r].stream_done;

endmodule

`default_nettype wire

// File: bench/tb_frame_location_stream_parser.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Frame location stream parser testbench
// Feeds header and location bytes with random gaps and output stalls, works
// out the frame results each accepted word must cause and checks every result
// word, field by field and in order, as it leaves the parser.
// ----------------------------------------------------------------------------

module tb_frame_location_stream_parser;

  localparam int unsigned RANDOM_WORDS    = 1500;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned PRESSURE_AFTER  = 40;
  localparam int unsigned PRESSURE_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 20;

  typedef enum logic [1:0] {
    EXPECT_HEADER,
    READ_FIRST,
    READ_SECOND,
    STREAM_ENDED
  } parse_phase_t;

  // Parser state mirror and the queue of frame results still to arrive.
  class frame_scoreboard_t;
    parse_phase_t       phase;
    logic [2:0]         loc_bytes;
    logic [3:0]         first_kind;
    logic [3:0]         second_kind;
    logic [63:0]        first_loc;
    logic [63:0]        second_loc;
    bit                 end_after_first;
    flsp_pkg::result_t  expected_frames[$];
    int unsigned        errors;

    function new();
      phase           = EXPECT_HEADER;
      loc_bytes       = '0;
      first_kind      = flsp_pkg::EMPTY_CODE;
      second_kind     = flsp_pkg::EMPTY_CODE;
      first_loc       = '0;
      second_loc      = '0;
      end_after_first = 1'b0;
      errors          = 0;
    endfunction

    function flsp_pkg::result_t make_result(logic [3:0] kind, logic [63:0] loc,
                                            bit frame, bit last, bit done);
      flsp_pkg::result_t r;
      r.frame_type     = kind;
      r.frame_location = loc;
      r.is_frame       = frame;
      r.last_in_run    = last;
      r.stream_done    = done;
      return r;
    endfunction

    // Appends one result to the tail of the awaited queue.
    function void await_result(flsp_pkg::result_t r);
      expected_frames.insert(expected_frames.size(), r);
    endfunction

    // A completed pair gives both frames, or only the first when the header
    // carried the end code in its low nibble.
    function void push_pair();
      if (end_after_first) begin
        await_result(make_result(first_kind, first_loc, 1'b1, 1'b1, 1'b1));
        phase = STREAM_ENDED;
      end else begin
        await_result(make_result(first_kind, first_loc, 1'b1, 1'b0, 1'b0));
        await_result(make_result(second_kind, second_loc, 1'b1, 1'b1, 1'b0));
        phase = EXPECT_HEADER;
      end
    endfunction

    // Takes one accepted word; returns 0 when the parser ignores it.
    function bit parse_word(logic [7:0] data, bit restart);
      logic [3:0] hi_kind;
      logic [3:0] lo_kind;
      hi_kind = data[7:4];
      lo_kind = data[3:0];
      if (restart) phase = EXPECT_HEADER;
      case (phase)
        STREAM_ENDED: return 1'b0;
        EXPECT_HEADER: begin
          loc_bytes = '0;
          if (hi_kind == flsp_pkg::END_CODE) begin
            // End code first: a lone marker word closes the stream.
            await_result(make_result(flsp_pkg::EMPTY_CODE, '0, 1'b0, 1'b1, 1'b1));
            phase = STREAM_ENDED;
          end else begin
            first_kind      = hi_kind;
            end_after_first = (lo_kind == flsp_pkg::END_CODE);
            second_kind     = end_after_first ? flsp_pkg::EMPTY_CODE : lo_kind;
            if (hi_kind != flsp_pkg::EMPTY_CODE) phase = READ_FIRST;
            else if (second_kind != flsp_pkg::EMPTY_CODE) phase = READ_SECOND;
            else push_pair();
          end
        end
        READ_FIRST: begin
          first_loc = {data, first_loc[63:8]};
          loc_bytes = loc_bytes + 3'd1;
          if (loc_bytes == 3'd0) begin
            if (second_kind != flsp_pkg::EMPTY_CODE) phase = READ_SECOND;
            else push_pair();
          end
        end
        default: begin
          second_loc = {data, second_loc[63:8]};
          loc_bytes  = loc_bytes + 3'd1;
          if (loc_bytes == 3'd0) push_pair();
        end
      endcase
      return 1'b1;
    endfunction

    // Compares one result word with the oldest frame still awaited.
    function void check_result(flsp_pkg::result_t got);
      flsp_pkg::result_t want;
      if (expected_frames.size() == 0) begin
        $error("unexpected result word: type %0d, location %h", got.frame_type,
               got.frame_location);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      if (got.frame_type !== want.frame_type) begin
        $error("frame_type: expected %0d, actual %0d", want.frame_type, got.frame_type);
        errors++;
      end
      if (got.frame_location !== want.frame_location) begin
        $error("frame_location: expected %h, actual %h", want.frame_location,
               got.frame_location);
        errors++;
      end
      if (got.is_frame !== want.is_frame) begin
        $error("is_frame: expected %0b, actual %0b", want.is_frame, got.is_frame);
        errors++;
      end
      if (got.last_in_run !== want.last_in_run) begin
        $error("last_in_run: expected %0b, actual %0b", want.last_in_run, got.last_in_run);
        errors++;
      end
      if (got.stream_done !== want.stream_done) begin
        $error("stream_done: expected %0b, actual %0b", want.stream_done, got.stream_done);
        errors++;
      end
    endfunction

    // Any frame still awaited at the end never arrived.
    function void wrap_up();
      if (expected_frames.size() != 0) begin
        $error("%0d result words never arrived", expected_frames.size());
        errors += expected_frames.size();
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  bit                sender_calm = 1'b0;
  int unsigned       random_parsed = 0;
  int unsigned       results_taken = 0;
  int unsigned       cycle_count = 0;
  frame_scoreboard_t board = new();

  flsp_in_if  in_chan ();
  flsp_out_if out_chan ();

  frame_location_stream_parser DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else if (roll < 98) return $urandom_range(4, 8);
    else return $urandom_range(20, 40);
  endfunction

  // Location bytes lean towards the extremes.
  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'h00;
    else if (roll == 1) return 8'hFF;
    else return 8'($urandom_range(0, 255));
  endfunction

  // Offers one word after an optional gap and waits until it is taken.
  task automatic send_word(input logic [7:0] data, input bit restart, output bit parsed);
    int unsigned gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= data;
    in_chan.restart   <= restart;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    parsed = board.parse_word(data, restart);
  endtask

  // Hand-picked streams covering the end codes, empty frames and restarts.
  task automatic run_directed();
    logic [7:0] first_bytes [8] = '{8'hFF, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hFF};
    bit         parsed;
    send_word(8'h00, 1'b1, parsed);   // both frames empty, locations still clear
    send_word(8'h0F, 1'b0, parsed);   // empty first frame, then the end
    send_word(8'h55, 1'b0, parsed);   // ignored after the end
    send_word(8'hF0, 1'b1, parsed);   // end code in the high nibble
    send_word(8'hFF, 1'b1, parsed);   // all ones also ends at once
    send_word(8'h3F, 1'b1, parsed);   // one located frame, then the end
    foreach (first_bytes[i]) send_word(first_bytes[i], 1'b0, parsed);
    send_word(8'h05, 1'b1, parsed);   // empty first, located second
    send_word(8'h11, 1'b0, parsed);
    send_word(8'h22, 1'b0, parsed);
    send_word(8'h33, 1'b0, parsed);
    send_word(8'h00, 1'b1, parsed);   // restart part way through a location
    send_word(8'hA0, 1'b0, parsed);   // located first, empty second
    for (int i = 0; i < 8; i++) send_word(8'(i + 1), 1'b0, parsed);
  endtask

  // One stream with random header and location bytes; now and then it is cut
  // short, or followed by bytes that must be ignored.
  task automatic send_random_stream();
    logic [3:0]  hi_kind;
    logic [3:0]  lo_kind;
    int unsigned roll;
    int unsigned loc_total;
    int unsigned cut;
    bit          restart;
    bit          broken;
    bit          parsed;
    roll    = $urandom_range(0, 99);
    hi_kind = (roll < 10) ? flsp_pkg::EMPTY_CODE :
              (roll < 15) ? flsp_pkg::END_CODE : 4'($urandom_range(1, 14));
    roll    = $urandom_range(0, 99);
    lo_kind = (roll < 15) ? flsp_pkg::EMPTY_CODE :
              (roll < 30) ? flsp_pkg::END_CODE : 4'($urandom_range(1, 14));
    loc_total = 0;
    if (hi_kind != flsp_pkg::EMPTY_CODE && hi_kind != flsp_pkg::END_CODE) loc_total += 8;
    if (hi_kind != flsp_pkg::END_CODE && lo_kind != flsp_pkg::EMPTY_CODE &&
        lo_kind != flsp_pkg::END_CODE) loc_total += 8;
    restart     = (board.phase != EXPECT_HEADER) || ($urandom_range(0, 4) == 0);
    sender_calm = ($urandom_range(0, 5) == 0);
    broken      = ($urandom_range(0, 19) == 0);
    cut         = (loc_total > 0) ? $urandom_range(0, loc_total - 1) : 0;
    send_word({hi_kind, lo_kind}, restart, parsed);
    random_parsed += parsed;
    for (int i = 0; i < loc_total; i++) begin
      if (broken && i == cut) break;
      send_word(pick_byte(), 1'b0, parsed);
      random_parsed += parsed;
    end
    if (board.phase == STREAM_ENDED && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)), 1'b0, parsed);
    end
  endtask

  // Stimulus, drain and verdict.
  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.data_byte = 8'h00;
    in_chan.restart   = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    while (random_parsed < RANDOM_WORDS) send_random_stream();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (board.expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.wrap_up();
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result receiver: random stalls, calm stretches, and one long hold-off
  // that lets the output queue fill and stall the input.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned calm_left;
    bit          pressure_done;
    out_chan.ready = 1'b0;
    stall_left     = 0;
    calm_left      = 0;
    pressure_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && results_taken >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        stall_left    = PRESSURE_CYCLES;
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(50, 150);
        else stall_left = pick_gap();
      end
    end
  end

  // Result monitor, sampled at the rising edge.
  always @(posedge clk) begin : monitor
    flsp_pkg::result_t got;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.frame_type     = out_chan.frame_type;
      got.frame_location = out_chan.frame_location;
      got.is_frame       = out_chan.is_frame;
      got.last_in_run    = out_chan.last_in_run;
      got.stream_done    = out_chan.stream_done;
      board.check_result(got);
      results_taken++;
    end
  end

  // Watchdog on the cycle count.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
